>>> rtl/sctd_pkg.sv
package sctd_pkg;

	// Day split: the biased second count is shifted right by 7 and divided by 675.
	localparam int DAY_SECONDS = 86400;
	localparam int DAY_LO_W = 7;
	localparam int DAY_DIV = DAY_SECONDS >> DAY_LO_W;
	localparam int DAY_BIAS_DAYS = 24856;
	localparam logic [32:0] DAY_BIAS = 33'(64'(DAY_BIAS_DAYS) * 64'(DAY_SECONDS));
	localparam int DAY_X_W = 33 - DAY_LO_W;
	localparam int DAY_Q_W = 16;
	localparam int DAY_SH = 27;
	localparam logic [17:0] DAY_MUL = 18'((64'd1 << DAY_SH) / DAY_DIV);
	localparam int SOD_W = 17;

	// Era placement. Every representable sum lands in era 4 or era 5.
	localparam int ERA_DAYS = 146097;
	localparam int DAYS_PER_CENT = 36524;
	localparam int EPOCH_DAYS = 730425;
	localparam int Z_OFS = EPOCH_DAYS - DAY_BIAS_DAYS;
	localparam int ERA5_Q = 5 * ERA_DAYS - Z_OFS;
	localparam int ERA4_OFS = Z_OFS - 4 * ERA_DAYS;
	localparam int ERA4_YEAR_OFS = 4 * 400 - 1900;
	localparam int ERA5_YEAR_OFS = 5 * 400 - 1900;

	// Reciprocal estimates; each is low by at most one and corrected a stage later.
	localparam int Q1460_DIV = 1460;
	localparam int Q1460_SH = 18;
	localparam logic [7:0] Q1460_MUL = 8'((64'd1 << Q1460_SH) / Q1460_DIV);
	localparam int YEAR_DIV = 365;
	localparam int YEAR_SH = 18;
	localparam logic [9:0] YEAR_MUL = 10'((64'd1 << YEAR_SH) / YEAR_DIV);
	localparam int MP_DIV = 153;
	localparam int MP_SH = 11;
	localparam logic [3:0] MP_MUL = 4'((64'd1 << MP_SH) / MP_DIV);
	localparam int SECS_PER_HOUR = 3600;
	localparam int HOUR_SH = 17;
	localparam logic [5:0] HOUR_MUL = 6'((64'd1 << HOUR_SH) / SECS_PER_HOUR);
	localparam int SECS_PER_MIN = 60;
	localparam int MIN_SH = 12;
	localparam logic [6:0] MIN_MUL = 7'((64'd1 << MIN_SH) / SECS_PER_MIN);

	// March-based month index of January, and the shift back to a January-based index.
	localparam int MP_JAN = 10;
	localparam int MP_MAR = 2;
	localparam int MONTH_FEB = 1;

	// Stage at which the date and time of day are both registered.
	localparam int RES_STAGE = 15;

	typedef struct packed {
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	// First day of year of each March-based month: (153 * mp + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/sctd_if.sv
interface sctd_stamp_if;
	logic valid;
	logic ready;
	logic signed [31:0] timestamp;
	logic signed [31:0] utc_offset;

	modport source (output valid, output timestamp, output utc_offset, input ready);
	modport sink (input valid, input timestamp, input utc_offset, output ready);
endinterface

interface sctd_civil_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [4:0] day_of_month;
	logic [3:0] month_index;
	logic [7:0] years_since_1900;
	logic signed [1:0] dst_flag;

	modport source (output valid, output valid_res, output second, output minute,
		output hour, output day_of_month, output month_index, output years_since_1900,
		output dst_flag, input ready);
	modport sink (input valid, input valid_res, input second, input minute,
		input hour, input day_of_month, input month_index, input years_since_1900,
		input dst_flag, output ready);
endinterface

>>> rtl/sctd_civil.sv
module sctd_civil (
	input  logic clk,
	input  logic en,
	input  logic [sctd_pkg::DAY_Q_W-1:0] q,
	output sctd_pkg::date_t date
);

	logic era5_c;
	logic [17:0] doe_c;
	logic [25:0] a_prod;
	logic [2:0] cent_c;
	logic [17:0] a_mul;
	logic [17:0] a_rem;
	logic [27:0] y_prod;
	logic [17:0] y_mul;
	logic [17:0] y_rem;
	logic [1:0] c100_c;
	logic [17:0] doy_base;
	logic [10:0] w_c;
	logic [14:0] mp_prod;
	logic [10:0] mp_mul;
	logic [10:0] mp_rem;
	logic [10:0] year_c;

	logic era5_s6, era5_s7, era5_s8, era5_s9, era5_s10, era5_s11, era5_s12, era5_s13, era5_s14;
	logic [17:0] doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [6:0] a0_s7, a_s8;
	logic [2:0] cent_s7, cent_s8;
	logic leap_s7, leap_s8;
	logic [17:0] t_s9, t_s10;
	logic [8:0] y0_s10, yoe_s11, yoe_s12, yoe_s13, yoe_s14;
	logic [8:0] doy_s12, doy_s13, doy_s14;
	logic [10:0] w_s13;
	logic [3:0] mp0_s13, mp_s14;

	assign era5_c = 18'(q) >= 18'(sctd_pkg::ERA5_Q);
	assign doe_c = era5_c ? 18'(q) - 18'(sctd_pkg::ERA5_Q) : 18'(q) + 18'(sctd_pkg::ERA4_OFS);

	assign a_prod = 26'(doe_s6) * 26'(sctd_pkg::Q1460_MUL);
	// Whole centuries inside the era; the last day of the era counts a fourth.
	assign cent_c = 3'(doe_s6 >= 18'(sctd_pkg::DAYS_PER_CENT))
		+ 3'(doe_s6 >= 18'(2 * sctd_pkg::DAYS_PER_CENT))
		+ 3'(doe_s6 >= 18'(3 * sctd_pkg::DAYS_PER_CENT))
		+ 3'(doe_s6 >= 18'(4 * sctd_pkg::DAYS_PER_CENT));

	assign a_mul = 18'(a0_s7) * 18'(sctd_pkg::Q1460_DIV);
	assign a_rem = doe_s7 - a_mul;

	assign y_prod = 28'(t_s9) * 28'(sctd_pkg::YEAR_MUL);
	assign y_mul = 18'(y0_s10) * 18'(sctd_pkg::YEAR_DIV);
	assign y_rem = t_s10 - y_mul;

	assign c100_c = 2'(yoe_s11 >= 9'd100) + 2'(yoe_s11 >= 9'd200) + 2'(yoe_s11 >= 9'd300);
	assign doy_base = 18'(yoe_s11) * 18'(sctd_pkg::YEAR_DIV) + 18'(yoe_s11[8:2]) - 18'(c100_c);

	assign w_c = 11'(doy_s12) * 11'd5 + 11'd2;
	assign mp_prod = 15'(w_c) * 15'(sctd_pkg::MP_MUL);
	assign mp_mul = 11'(mp0_s13) * 11'(sctd_pkg::MP_DIV);
	assign mp_rem = w_s13 - mp_mul;

	assign year_c = 11'(yoe_s14)
		+ (era5_s14 ? 11'(sctd_pkg::ERA5_YEAR_OFS) : 11'(sctd_pkg::ERA4_YEAR_OFS))
		+ 11'(mp_s14 >= 4'(sctd_pkg::MP_JAN));

	always_ff @(posedge clk) begin
		if (en) begin
			era5_s6 <= era5_c;
			doe_s6 <= doe_c;

			era5_s7 <= era5_s6;
			doe_s7 <= doe_s6;
			a0_s7 <= a_prod[sctd_pkg::Q1460_SH +: 7];
			cent_s7 <= cent_c;
			leap_s7 <= doe_s6 == 18'(sctd_pkg::ERA_DAYS - 1);

			era5_s8 <= era5_s7;
			doe_s8 <= doe_s7;
			a_s8 <= a0_s7 + 7'(a_rem >= 18'(sctd_pkg::Q1460_DIV));
			cent_s8 <= cent_s7;
			leap_s8 <= leap_s7;

			era5_s9 <= era5_s8;
			doe_s9 <= doe_s8;
			t_s9 <= doe_s8 - 18'(a_s8) + 18'(cent_s8) - 18'(leap_s8);

			era5_s10 <= era5_s9;
			doe_s10 <= doe_s9;
			t_s10 <= t_s9;
			y0_s10 <= y_prod[sctd_pkg::YEAR_SH +: 9];

			era5_s11 <= era5_s10;
			doe_s11 <= doe_s10;
			yoe_s11 <= y0_s10 + 9'(y_rem >= 18'(sctd_pkg::YEAR_DIV));

			era5_s12 <= era5_s11;
			yoe_s12 <= yoe_s11;
			doy_s12 <= 9'(doe_s11 - doy_base);

			era5_s13 <= era5_s12;
			yoe_s13 <= yoe_s12;
			doy_s13 <= doy_s12;
			w_s13 <= w_c;
			mp0_s13 <= mp_prod[sctd_pkg::MP_SH +: 4];

			era5_s14 <= era5_s13;
			yoe_s14 <= yoe_s13;
			doy_s14 <= doy_s13;
			mp_s14 <= mp0_s13 + 4'(mp_rem >= 11'(sctd_pkg::MP_DIV));

			date.day <= 5'(doy_s14 - sctd_pkg::month_start(mp_s14) + 9'd1);
			date.month <= (mp_s14 < 4'(sctd_pkg::MP_JAN)) ? mp_s14 + 4'(sctd_pkg::MP_MAR)
				: mp_s14 - 4'(sctd_pkg::MP_JAN);
			date.year <= year_c[7:0];
		end
	end

endmodule

>>> rtl/sctd_tod.sv
module sctd_tod (
	input  logic clk,
	input  logic en,
	input  logic [sctd_pkg::SOD_W-1:0] sod,
	output sctd_pkg::tod_t tod
);

	// The split is done by stage 9 and then held in step with the date lane.
	localparam int TOD_DLY = sctd_pkg::RES_STAGE - 9;

	logic [21:0] h_prod;
	logic [16:0] h_mul;
	logic [16:0] h_rem;
	logic h_ge;
	logic [17:0] m_prod;
	logic [11:0] m_mul;
	logic [11:0] m_rem;
	logic m_ge;

	logic [sctd_pkg::SOD_W-1:0] sod_s6;
	logic [4:0] h0_s6, hour_s7, hour_s8;
	logic [11:0] rh_s7, rh_s8;
	logic [5:0] m0_s8;
	sctd_pkg::tod_t tod_s9;
	sctd_pkg::tod_t tod_dly_q [TOD_DLY];

	assign h_prod = 22'(sod) * 22'(sctd_pkg::HOUR_MUL);
	assign h_mul = 17'(h0_s6) * 17'(sctd_pkg::SECS_PER_HOUR);
	assign h_rem = sod_s6 - h_mul;
	assign h_ge = h_rem >= 17'(sctd_pkg::SECS_PER_HOUR);

	assign m_prod = 18'(rh_s7) * 18'(sctd_pkg::MIN_MUL);
	assign m_mul = 12'(m0_s8) * 12'(sctd_pkg::SECS_PER_MIN);
	assign m_rem = rh_s8 - m_mul;
	assign m_ge = m_rem >= 12'(sctd_pkg::SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en) begin
			sod_s6 <= sod;
			h0_s6 <= h_prod[sctd_pkg::HOUR_SH +: 5];

			hour_s7 <= h0_s6 + 5'(h_ge);
			rh_s7 <= 12'(h_ge ? h_rem - 17'(sctd_pkg::SECS_PER_HOUR) : h_rem);

			hour_s8 <= hour_s7;
			rh_s8 <= rh_s7;
			m0_s8 <= m_prod[sctd_pkg::MIN_SH +: 6];

			tod_s9.hour <= hour_s8;
			tod_s9.minute <= m0_s8 + 6'(m_ge);
			tod_s9.second <= 6'(m_ge ? m_rem - 12'(sctd_pkg::SECS_PER_MIN) : m_rem);

			tod_dly_q[0] <= tod_s9;
			for (int i = 1; i < TOD_DLY; i++) begin
				tod_dly_q[i] <= tod_dly_q[i-1];
			end
		end
	end

	assign tod = tod_dly_q[TOD_DLY-1];

endmodule

>>> rtl/seconds_to_civil_date_time_top.sv
// Channel   Dir  Handshake      Payload
// stamp     in   valid/ready    timestamp, utc_offset (signed 32-bit each)
// civil     out  valid/ready    valid_res, second, minute, hour, day_of_month,
//                               month_index, years_since_1900, dst_flag
// cfg       in   cfg_we         cfg_data (dst_mode, 2-bit signed)
//
// One request is taken every cycle while stamp.ready is high; each result passes
// sixteen register stages: offset add, day split, date and time lanes, output.
// Reset clears every stage valid bit and sets dst_mode to -1.
// When the output holds a result that is not taken, all stages freeze together;
// stamp.ready is low in exactly those cycles.
module seconds_to_civil_date_time_top (
	input  logic clk,
	input  logic arst_n,
	sctd_stamp_if.sink stamp,
	sctd_civil_if.source civil,
	input  logic cfg_we,
	input  logic [1:0] cfg_data
);

	localparam int NSTG = sctd_pkg::RES_STAGE + 1;

	logic en;
	logic ovf_c;
	logic [32:0] biased;
	logic [43:0] day_prod;
	logic [25:0] day_mul;
	logic day_ge;
	sctd_pkg::date_t date_s15;
	sctd_pkg::tod_t tod_s15;

	logic [1:0] dst_mode_q;
	logic [NSTG:1] vld_s;
	logic [NSTG-1:2] ovf_s;
	logic [32:0] sum_s1;
	logic [sctd_pkg::DAY_X_W-1:0] x_s2, x_s3;
	logic [sctd_pkg::DAY_LO_W-1:0] lo_s2, lo_s3, lo_s4;
	logic [sctd_pkg::DAY_Q_W-1:0] q0_s3, q0_s4, q_s5;
	logic [10:0] r0_s4;
	logic [sctd_pkg::SOD_W-1:0] sod_s5;
	logic res_ok_s16;
	sctd_pkg::date_t date_s16;
	sctd_pkg::tod_t tod_s16;
	logic [1:0] dst_s16;

	assign en = !vld_s[NSTG] || civil.ready;
	assign stamp.ready = en;

	assign ovf_c = sum_s1[32] ^ sum_s1[31];
	// Adding whole days keeps the count positive so floor division is plain.
	assign biased = sum_s1 + sctd_pkg::DAY_BIAS;
	assign day_prod = 44'(x_s2) * 44'(sctd_pkg::DAY_MUL);
	assign day_mul = 26'(q0_s3) * 26'(sctd_pkg::DAY_DIV);
	assign day_ge = r0_s4 >= 11'(sctd_pkg::DAY_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_mode_q <= 2'b11;
		end else if (cfg_we) begin
			dst_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], stamp.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= {stamp.timestamp[31], stamp.timestamp}
				+ {stamp.utc_offset[31], stamp.utc_offset};

			ovf_s <= {ovf_s[NSTG-2:2], ovf_c};
			x_s2 <= biased[32:sctd_pkg::DAY_LO_W];
			lo_s2 <= biased[sctd_pkg::DAY_LO_W-1:0];

			x_s3 <= x_s2;
			lo_s3 <= lo_s2;
			q0_s3 <= day_prod[sctd_pkg::DAY_SH +: sctd_pkg::DAY_Q_W];

			q0_s4 <= q0_s3;
			lo_s4 <= lo_s3;
			r0_s4 <= 11'(x_s3 - day_mul);

			q_s5 <= q0_s4 + {{(sctd_pkg::DAY_Q_W-1){1'b0}}, day_ge};
			sod_s5 <= {day_ge ? 10'(r0_s4 - 11'(sctd_pkg::DAY_DIV)) : r0_s4[9:0], lo_s4};

			res_ok_s16 <= !ovf_s[NSTG-1];
			date_s16 <= ovf_s[NSTG-1] ? '0 : date_s15;
			tod_s16 <= ovf_s[NSTG-1] ? '0 : tod_s15;
			dst_s16 <= ovf_s[NSTG-1] ? 2'b00 : (dst_mode_q[1] ? 2'b11 : dst_mode_q);
		end
	end

	sctd_civil u_civil (
		.clk  (clk),
		.en   (en),
		.q    (q_s5),
		.date (date_s15)
	);

	sctd_tod u_tod (
		.clk (clk),
		.en  (en),
		.sod (sod_s5),
		.tod (tod_s15)
	);

	assign civil.valid = vld_s[NSTG];
	assign civil.valid_res = res_ok_s16;
	assign civil.second = tod_s16.second;
	assign civil.minute = tod_s16.minute;
	assign civil.hour = tod_s16.hour;
	assign civil.day_of_month = date_s16.day;
	assign civil.month_index = date_s16.month;
	assign civil.years_since_1900 = date_s16.year;
	assign civil.dst_flag = dst_s16;

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		civil.valid && !civil.valid_res |-> civil.second == 6'd0 && civil.minute == 6'd0
			&& civil.hour == 5'd0 && civil.day_of_month == 5'd0 && civil.month_index == 4'd0
			&& civil.years_since_1900 == 8'd0 && civil.dst_flag == 2'sd0)
		else $error("overflowed request produced nonzero fields");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		civil.valid && civil.valid_res |-> civil.second < 6'd60 && civil.minute < 6'd60
			&& civil.hour < 5'd24 && civil.month_index < 4'd12 && civil.day_of_month != 5'd0
			&& civil.dst_flag != -2'sd2)
		else $error("result field out of range");

	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		civil.valid && civil.valid_res && civil.month_index == 4'(sctd_pkg::MONTH_FEB)
			|-> civil.day_of_month <= 5'd29)
		else $error("February day beyond 29");

endmodule
